[rtl/core/lfpb_pkg.sv]
// ----------------------------------------------------------------------------
// lfpb_pkg
// Types, constants and the brightness table of the LED afterglow block.
// ----------------------------------------------------------------------------
package lfpb_pkg;

  localparam int unsigned TABLE_ENTRIES = 41;
  localparam int unsigned CHANNELS      = 3;

  localparam logic [12:0] ONE_Q12    = 13'd4096;
  localparam logic [15:0] GLOW_CLAMP = 16'd40960;
  localparam logic [12:0] SHADE_MUL  = 13'd39;
  localparam logic [16:0] SHADE_MAX  = 17'd40;

  localparam logic [1:0] CFG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_RETAIN      = 2'd1;
  localparam logic [1:0] CFG_BLEED       = 2'd2;

  localparam logic [10:0] PIXEL_COUNT_RST = 11'd100;
  localparam logic [12:0] RETAIN_RST      = 13'd164;
  localparam logic [12:0] BLEED_RST       = 13'd0;

  localparam logic [7:0] BRIGHT_TAB [TABLE_ENTRIES] = '{
    8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
    8'd8,   8'd10,  8'd12,  8'd14,  8'd16,  8'd18,  8'd20,  8'd22,
    8'd24,  8'd28,  8'd32,  8'd36,  8'd40,  8'd44,  8'd48,  8'd52,
    8'd56,  8'd64,  8'd72,  8'd80,  8'd88,  8'd96,  8'd104, 8'd112,
    8'd120, 8'd136, 8'd152, 8'd168, 8'd184, 8'd200, 8'd216, 8'd232,
    8'd255
  };

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_pixel;
  } out_item_t;

  typedef logic [2:0][16:0] glow_t;
  typedef logic [2:0][15:0] chan16_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_WB,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_FRESH,
    OP_SHARE,
    OP_SHADE
  } op_t;

endpackage

[rtl/core/lfpb_glow_mem.sv]
// ----------------------------------------------------------------------------
// lfpb_glow_mem
// Glow store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module lfpb_glow_mem
  import lfpb_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  glow_t         wdata,
  input  logic [AW-1:0] raddr,
  output glow_t         rdata
);

  glow_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lfpb_mul_unit.sv]
// ----------------------------------------------------------------------------
// lfpb_mul_unit
// Shared Q1.12 multiplier with fade, bleed and brightness post-processing.
// ----------------------------------------------------------------------------
module lfpb_mul_unit
  import lfpb_pkg::*;
(
  input  op_t         op,
  input  logic [12:0] keep,
  input  logic [12:0] bleed,
  input  logic [15:0] opnd,
  input  logic [12:0] excite,
  output logic [15:0] res
);

  logic [12:0] coef;
  logic [28:0] prod;
  logic [16:0] scaled;
  logic [5:0]  tab_idx;

  always_comb begin
    case (op)
      OP_FRESH: coef = keep;
      OP_SHARE: coef = bleed;
      OP_SHADE: coef = SHADE_MUL;
      default:  coef = SHADE_MUL;
    endcase
    prod    = 29'(coef) * 29'(opnd);
    scaled  = prod[28:12];
    tab_idx = (scaled > SHADE_MAX) ? SHADE_MAX[5:0] : scaled[5:0];
    case (op)
      OP_FRESH: res = 16'(scaled + 17'(excite));
      OP_SHARE: res = scaled[15:0];
      OP_SHADE: res = {8'd0, BRIGHT_TAB[tab_idx]};
      default:  res = '0;
    endcase
  end

endmodule

[rtl/core/led_frame_persist_bleed.sv]
// ----------------------------------------------------------------------------
// led_frame_persist_bleed
// Per-pixel afterglow with neighbor bleed and exponential brightness mapping.
// ----------------------------------------------------------------------------
// A result is registered once its input has passed the load, multiply (nine
// passes through the one shared multiplier), write-back and finish steps, and
// the finish step waits while an earlier result is stalled. A new input is taken
// in the cycle after the result is loaded. After reset the whole glow store is
// cleared, one entry a cycle, taking no input; configuration writes are taken.
module led_frame_persist_bleed
  import lfpb_pkg::*;
#(
  parameter int MAX_PIXELS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);

  localparam int IDXW = $clog2(MAX_PIXELS);
  localparam logic [16:0] LIM_MAX = 17'(MAX_PIXELS - 1);
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_PIXELS - 1);

  state_t          state_r, state_nxt;
  logic [10:0]     pixel_count_r;
  logic [12:0]     retain_r, bleed_r;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [IDXW-1:0] clr_addr_r, clr_addr_nxt;
  chan16_t         carry_r, carry_nxt;
  chan16_t         pend_r, pend_nxt;
  logic            pv_r, pv_nxt;
  in_item_t        item_r, item_nxt;
  logic            last_r, last_nxt;
  chan16_t         g_r, g_nxt;
  chan16_t         fresh_r, fresh_nxt;
  chan16_t         share_r, share_nxt;
  logic [2:0][7:0] shade_r, shade_nxt;
  op_t             phase_r, phase_nxt;
  logic [1:0]      chan_r, chan_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [12:0]     keep, bleed_q;
  logic [16:0]     lim;
  logic            last_in;
  glow_t           rd_data;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  glow_t           mem_wdata;
  logic [15:0]     unit_opnd;
  logic [12:0]     unit_excite;
  logic [15:0]     unit_res;
  logic [15:0]     chan_raw;
  logic [17:0]     load_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= PIXEL_COUNT_RST;
      retain_r      <= RETAIN_RST;
      bleed_r       <= BLEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PIXEL_COUNT: pixel_count_r <= cfg_wdata[10:0];
        CFG_RETAIN:      retain_r      <= cfg_wdata;
        CFG_BLEED:       bleed_r       <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_comb begin
    keep    = ONE_Q12 - ((retain_r > ONE_Q12) ? ONE_Q12 : retain_r);
    bleed_q = (bleed_r > ONE_Q12) ? ONE_Q12 : bleed_r;
    lim     = (pixel_count_r == 11'd0) ? 17'd0 : 17'(pixel_count_r - 11'd1);
    if (lim > LIM_MAX) begin
      lim = LIM_MAX;
    end
    last_in = in_data.frame_end || (17'(idx_r) >= lim);
  end

  lfpb_glow_mem #(
    .DEPTH (MAX_PIXELS),
    .AW    (IDXW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  always_comb begin
    case (chan_r)
      2'd0:    chan_raw = item_r.red_in;
      2'd1:    chan_raw = item_r.green_in;
      default: chan_raw = item_r.blue_in;
    endcase
    unit_excite = (chan_raw > 16'(ONE_Q12)) ? ONE_Q12 : chan_raw[12:0];
    unit_opnd   = (phase_r == OP_SHADE) ? fresh_r[chan_r] : g_r[chan_r];
  end

  lfpb_mul_unit u_mul (
    .op     (phase_r),
    .keep   (keep),
    .bleed  (bleed_q),
    .opnd   (unit_opnd),
    .excite (unit_excite),
    .res    (unit_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      idx_r       <= '0;
      carry_r     <= '0;
      pend_r      <= '0;
      pv_r        <= 1'b0;
      phase_r     <= OP_FRESH;
      chan_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      idx_r       <= idx_nxt;
      carry_r     <= carry_nxt;
      pend_r      <= pend_nxt;
      pv_r        <= pv_nxt;
      phase_r     <= phase_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    last_r     <= last_nxt;
    g_r        <= g_nxt;
    fresh_r    <= fresh_nxt;
    share_r    <= share_nxt;
    shade_r    <= shade_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    idx_nxt       = idx_r;
    carry_nxt     = carry_r;
    pend_nxt      = pend_r;
    pv_nxt        = pv_r;
    item_nxt      = item_r;
    last_nxt      = last_r;
    g_nxt         = g_r;
    fresh_nxt     = fresh_r;
    share_nxt     = share_r;
    shade_nxt     = shade_r;
    phase_nxt     = phase_r;
    chan_nxt      = chan_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '0;
    load_sum      = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          last_nxt  = last_in;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        for (int c = 0; c < CHANNELS; c++) begin
          load_sum = 18'(rd_data[c]) + 18'(carry_r[c]);
          g_nxt[c] = (load_sum > 18'(GLOW_CLAMP)) ? GLOW_CLAMP : load_sum[15:0];
        end
        phase_nxt = OP_FRESH;
        chan_nxt  = 2'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        case (phase_r)
          OP_FRESH: fresh_nxt[chan_r] = unit_res;
          OP_SHARE: share_nxt[chan_r] = unit_res;
          OP_SHADE: shade_nxt[chan_r] = unit_res[7:0];
          default:  ;
        endcase
        if (chan_r == 2'd2) begin
          chan_nxt = 2'd0;
          case (phase_r)
            OP_FRESH: phase_nxt = OP_SHARE;
            OP_SHARE: phase_nxt = OP_SHADE;
            default:  state_nxt = ST_WB;
          endcase
        end else begin
          chan_nxt = chan_r + 2'd1;
        end
      end
      ST_WB: begin
        mem_we    = pv_r;
        mem_waddr = idx_r - 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          mem_wdata[c] = 17'(pend_r[c]) + 17'(share_r[c]);
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        mem_we    = last_r;
        mem_waddr = idx_r;
        for (int c = 0; c < CHANNELS; c++) begin
          mem_wdata[c] = 17'(fresh_r[c]);
        end
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.red_out    = shade_r[0];
          out_data_nxt.green_out  = shade_r[1];
          out_data_nxt.blue_out   = shade_r[2];
          out_data_nxt.last_pixel = last_r;
          if (last_r) begin
            carry_nxt = '0;
            pend_nxt  = '0;
            pv_nxt    = 1'b0;
            idx_nxt   = '0;
          end else begin
            carry_nxt = share_r;
            pend_nxt  = fresh_r;
            pv_nxt    = 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/lfpb_checker.sv]
// ----------------------------------------------------------------------------
// lfpb_checker
// Port-level checks of the LED afterglow block, bound to the top level.
// ----------------------------------------------------------------------------
module lfpb_checker
  import lfpb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result keeps its value until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block works on one pixel at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a pixel is in progress");

  // The clearing pass follows reset, so no input is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during glow store clearing");

  // A new result only appears while the block is busy with a pixel.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

endmodule

bind led_frame_persist_bleed lfpb_checker u_lfpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/tb_led_frame_persist_bleed.sv]
// ----------------------------------------------------------------------------
// tb_led_frame_persist_bleed
// Self-checking testbench for the LED afterglow and neighbor bleed block.
// Pixels are sent in frames while the result side stalls on a pattern of its
// own. A behavioral copy of the glow store, carry and write-back logic
// predicts every drive byte, and each result transfer is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_led_frame_persist_bleed;
  import lfpb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIX_DEPTH = 1024;
  localparam int unsigned Q12_ONE = 4096;
  localparam int unsigned CLAMP_IN = 40960;
  localparam int unsigned STORE_MAX = 131071;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned DRAIN_LIMIT = 20000;

  localparam logic [7:0] LEVEL_LUT [41] = '{
    8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
    8'd8,   8'd10,  8'd12,  8'd14,  8'd16,  8'd18,  8'd20,  8'd22,
    8'd24,  8'd28,  8'd32,  8'd36,  8'd40,  8'd44,  8'd48,  8'd52,
    8'd56,  8'd64,  8'd72,  8'd80,  8'd88,  8'd96,  8'd104, 8'd112,
    8'd120, 8'd136, 8'd152, 8'd168, 8'd184, 8'd200, 8'd216, 8'd232,
    8'd255
  };

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_COMB
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_PIXEL_COUNT;
  logic [12:0] cfg_wdata = '0;

  // Predictor state.
  logic [16:0] glow_mem [PIX_DEPTH][3];
  logic [9:0]  pix_pos;
  logic [16:0] carry_glow [3];
  logic [16:0] held_glow [3];
  logic        held_ok;
  logic [10:0] count_reg;
  logic [12:0] retain_reg;
  logic [12:0] bleed_reg;

  out_item_t drive_due [$];
  int unsigned err_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned hold_cycles = 0;
  int unsigned rx_tick = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  always #2 clk = ~clk;

  led_frame_persist_bleed u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  function automatic logic [16:0] sat17(input int unsigned v);
    return (v > STORE_MAX) ? 17'h1FFFF : v[16:0];
  endfunction

  function automatic logic [7:0] drive_level(input int unsigned g);
    int unsigned k;
    k = (39 * g) >> 12;
    if (k > 40) begin
      k = 40;
    end
    return LEVEL_LUT[k];
  endfunction

  function automatic logic [15:0] rand_excite();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd4096;
      2: return 16'($urandom_range(0, 65535));
      3: return 16'($urandom_range(4097, 65535));
      default: return 16'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic reset_model();
    for (int p = 0; p < PIX_DEPTH; p++) begin
      for (int c = 0; c < 3; c++) begin
        glow_mem[p][c] = '0;
      end
    end
    for (int c = 0; c < 3; c++) begin
      carry_glow[c] = '0;
      held_glow[c] = '0;
    end
    pix_pos = '0;
    held_ok = 1'b0;
    count_reg = PIXEL_COUNT_RST;
    retain_reg = RETAIN_RST;
    bleed_reg = BLEED_RST;
  endtask

  // Works out the drive bytes of one pixel and advances the glow state.
  task automatic predict_pixel(input in_item_t px);
    int unsigned cnt, keep, bl, idx, g, e;
    int unsigned fresh [3];
    int unsigned share [3];
    logic [15:0] exc [3];
    logic [7:0]  lvl [3];
    logic        ends;
    out_item_t   r;
    cnt = count_reg;
    if (cnt < 1) begin
      cnt = 1;
    end
    if (cnt > PIX_DEPTH) begin
      cnt = PIX_DEPTH;
    end
    keep = Q12_ONE - ((retain_reg > Q12_ONE) ? Q12_ONE : retain_reg);
    bl = (bleed_reg > Q12_ONE) ? Q12_ONE : bleed_reg;
    idx = pix_pos;
    ends = px.frame_end || (idx >= cnt - 1);
    exc[0] = px.red_in;
    exc[1] = px.green_in;
    exc[2] = px.blue_in;
    for (int c = 0; c < 3; c++) begin
      e = (exc[c] > Q12_ONE) ? Q12_ONE : exc[c];
      g = sat17(glow_mem[idx][c] + carry_glow[c]);
      if (g > CLAMP_IN) begin
        g = CLAMP_IN;
      end
      fresh[c] = ((keep * g) >> 12) + e;
      share[c] = (bl * g) >> 12;
      lvl[c] = drive_level(fresh[c]);
    end
    r.red_out = lvl[0];
    r.green_out = lvl[1];
    r.blue_out = lvl[2];
    r.last_pixel = ends;
    if (held_ok && idx > 0) begin
      for (int c = 0; c < 3; c++) begin
        glow_mem[idx - 1][c] = sat17(held_glow[c] + share[c]);
      end
    end
    if (ends) begin
      for (int c = 0; c < 3; c++) begin
        glow_mem[idx][c] = sat17(fresh[c]);
        carry_glow[c] = '0;
        held_glow[c] = '0;
      end
      held_ok = 1'b0;
      pix_pos = '0;
    end else begin
      for (int c = 0; c < 3; c++) begin
        held_glow[c] = sat17(fresh[c]);
        carry_glow[c] = share[c][16:0];
      end
      held_ok = 1'b1;
      pix_pos = 10'(idx + 1);
    end
    drive_due.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", result_cnt, msg);
    err_cnt++;
  endtask

  // Entered and left at a falling edge.
  task automatic send_pixel(input in_item_t px);
    in_valid <= 1'b1;
    in_data <= px;
    do begin
      @(posedge clk);
    end while (!(in_valid && in_ready));
    predict_pixel(px);
    @(negedge clk);
  endtask

  task automatic pause_input(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_plain(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                            input logic fe);
    in_item_t px;
    px.red_in = r;
    px.green_in = g;
    px.blue_in = b;
    px.frame_end = fe;
    send_pixel(px);
  endtask

  // Lowers valid and waits until every predicted result has arrived or the drain limit runs out.
  task automatic settle();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (drive_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PIXEL_COUNT: count_reg = val[10:0];
      CFG_RETAIN:      retain_reg = val;
      CFG_BLEED:       bleed_reg = val;
      default:         ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_stream(input int unsigned n_items, input int unsigned frame_len,
                             input bit noisy);
    in_item_t    px;
    int unsigned pos, burst;
    pos = 0;
    burst = $urandom_range(1, 16);
    for (int unsigned i = 0; i < n_items; i++) begin
      px.red_in = rand_excite();
      px.green_in = rand_excite();
      px.blue_in = rand_excite();
      if (noisy) begin
        px.frame_end = ($urandom_range(0, 15) == 0);
      end else begin
        px.frame_end = (pos == frame_len - 1);
      end
      pos = px.frame_end ? 0 : pos + 1;
      send_pixel(px);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) begin
          pause_input($urandom_range(1, 30));
        end
      end
    end
  endtask

  task automatic test_field_extremes();
    send_plain(16'd0, 16'd0, 16'd0, 1'b0);
    send_plain(16'd4096, 16'd4096, 16'd4096, 1'b0);
    send_plain(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_plain(16'd4097, 16'd1, 16'd4095, 1'b0);
    send_plain(16'h5555, 16'hAAAA, 16'd2048, 1'b1);
    send_plain(16'd4096, 16'd0, 16'hFFFF, 1'b1);
    settle();
  endtask

  task automatic test_frame_boundaries();
    write_reg(CFG_PIXEL_COUNT, 13'd3);
    send_plain(16'd4096, 16'd1000, 16'd0, 1'b0);
    send_plain(16'd300, 16'd4096, 16'd77, 1'b0);
    send_plain(16'd0, 16'd0, 16'd4096, 1'b0);
    send_plain(16'd4096, 16'd4096, 16'd4096, 1'b1);
    settle();
    write_reg(CFG_PIXEL_COUNT, 13'd1);
    send_plain(16'd123, 16'd4096, 16'd900, 1'b0);
    send_plain(16'd0, 16'd12, 16'd4096, 1'b0);
    settle();
  endtask

  // Shrinking the count below the current position ends the frame at once.
  task automatic test_count_shrink();
    write_reg(CFG_PIXEL_COUNT, 13'd8);
    write_reg(CFG_BLEED, 13'd1024);
    for (int i = 0; i < 5; i++) begin
      send_plain(16'd4096, 16'(i * 800), 16'd2000, 1'b0);
    end
    settle();
    write_reg(CFG_PIXEL_COUNT, 13'd2);
    send_plain(16'd500, 16'd500, 16'd500, 1'b0);
    send_plain(16'd4096, 16'd0, 16'd4096, 1'b0);
    settle();
  endtask

  task automatic test_register_limits();
    write_reg(CFG_PIXEL_COUNT, 13'd0);
    write_reg(CFG_RETAIN, 13'h1FFF);
    write_reg(CFG_BLEED, 13'h1FFF);
    send_plain(16'd4096, 16'd4096, 16'd4096, 1'b0);
    send_plain(16'd100, 16'd4096, 16'd0, 1'b0);
    settle();
    write_reg(CFG_PIXEL_COUNT, 13'h7FF);
    write_reg(CFG_RETAIN, 13'd0);
    write_reg(CFG_BLEED, 13'd4096);
    send_plain(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_plain(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_plain(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned cnt, ret, bl, eff, flen;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin cnt = 4;    ret = 164;  bl = 0;    end
        1: begin cnt = 1;    ret = 0;    bl = 0;    end
        2: begin cnt = 6;    ret = 0;    bl = 4096; end
        3: begin cnt = 3;    ret = 4096; bl = 4096; end
        4: begin cnt = 1025; ret = 2000; bl = 300;  end
        5: begin cnt = 1024; ret = $urandom_range(0, 4096); bl = $urandom_range(0, 4096); end
        default: begin
          cnt = $urandom_range(1, 12);
          ret = $urandom_range(0, 8191);
          bl = $urandom_range(0, 8191);
        end
      endcase
      write_reg(CFG_PIXEL_COUNT, 13'(cnt));
      write_reg(CFG_RETAIN, 13'(ret));
      write_reg(CFG_BLEED, 13'(bl));
      eff = (cnt > PIX_DEPTH) ? PIX_DEPTH : cnt;
      flen = (eff <= 16 && $urandom_range(0, 3) != 0) ? eff : $urandom_range(1, 20);
      send_stream(50, flen, 1'b0);
      send_stream(10, flen, 1'b1);
      settle();
    end
  endtask

  // The result side holds off while pixels keep coming, so the input stalls.
  task automatic test_output_hold();
    write_reg(CFG_PIXEL_COUNT, 13'd5);
    write_reg(CFG_RETAIN, 13'd800);
    write_reg(CFG_BLEED, 13'd600);
    hold_cycles = 400;
    send_stream(40, 5, 1'b0);
    settle();
  endtask

  task automatic test_drain_pause();
    send_stream(20, 5, 1'b0);
    in_valid <= 1'b0;
    while (drive_due.size() != 0) begin
      @(negedge clk);
    end
    @(negedge clk);
    send_stream(20, 5, 1'b0);
    settle();
  endtask

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      if (rx_tick % 256 == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_ready <= ($urandom_range(0, 2) == 0);
        default:  out_ready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        report_mismatch("result transfer with no pixel outstanding");
      end else begin
        want = drive_due.pop_front();
        if (out_data.red_out !== want.red_out) begin
          report_mismatch($sformatf("red_out got %0d expected %0d",
                                    out_data.red_out, want.red_out));
        end
        if (out_data.green_out !== want.green_out) begin
          report_mismatch($sformatf("green_out got %0d expected %0d",
                                    out_data.green_out, want.green_out));
        end
        if (out_data.blue_out !== want.blue_out) begin
          report_mismatch($sformatf("blue_out got %0d expected %0d",
                                    out_data.blue_out, want.blue_out));
        end
        if (out_data.last_pixel !== want.last_pixel) begin
          report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                    out_data.last_pixel, want.last_pixel));
        end
      end
      result_cnt++;
    end
  end

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_field_extremes();
    test_frame_boundaries();
    test_count_shrink();
    test_register_limits();
    test_random_frames();
    test_output_hold();
    test_drain_pause();
    settle();
    if (drive_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", drive_due.size()));
    end
    if (err_cnt == 0) begin
      $display("tb_led_frame_persist_bleed: clean");
    end else begin
      $display("tb_led_frame_persist_bleed: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_led_frame_persist_bleed: errors");
    $finish;
  end

endmodule
